// ----- sv/hts_pkg.sv -----
`timescale 1ns / 1ps

package hts_pkg;

  // jamo index constants
  localparam logic [4:0]  NONE_JAMO         = 5'd31;
  localparam logic [4:0]  IEUNG             = 5'd11;
  localparam logic [4:0]  N_LEADS           = 5'd19;
  localparam logic [4:0]  N_VOWELS          = 5'd21;
  localparam logic [4:0]  N_TAILS           = 5'd28;
  localparam logic [15:0] SYL_BASE          = 16'hAC00;
  localparam logic [15:0] LEAD_COMPAT_BASE  = 16'h3131;
  localparam logic [15:0] VOWEL_COMPAT_BASE = 16'h314F;
  localparam logic [20:0] ASCII_MAX         = 21'h7F;

  // request kinds
  typedef enum logic [1:0] {
    REQ_CHAR      = 2'd0,
    REQ_BACKSPACE = 2'd1,
    REQ_RESET     = 2'd2,
    REQ_COMMIT    = 2'd3
  } req_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic decode;
    logic exec;
  } cmd_t;

  // consonant keys to lead index
  function automatic logic [4:0] key_lead(logic [6:0] ch);
    case (ch)
      7'h72: return 5'd0;   // r
      7'h52: return 5'd1;   // R
      7'h73: return 5'd2;   // s
      7'h65: return 5'd3;   // e
      7'h45: return 5'd4;   // E
      7'h66: return 5'd5;   // f
      7'h61: return 5'd6;   // a
      7'h71: return 5'd7;   // q
      7'h51: return 5'd8;   // Q
      7'h74: return 5'd9;   // t
      7'h54: return 5'd10;  // T
      7'h64: return 5'd11;  // d
      7'h77: return 5'd12;  // w
      7'h57: return 5'd13;  // W
      7'h63: return 5'd14;  // c
      7'h7A: return 5'd15;  // z
      7'h78: return 5'd16;  // x
      7'h76: return 5'd17;  // v
      7'h67: return 5'd18;  // g
      default: return NONE_JAMO;
    endcase
  endfunction

  // vowel keys to vowel index
  function automatic logic [4:0] key_vowel(logic [6:0] ch);
    case (ch)
      7'h6B: return 5'd0;   // k
      7'h6F: return 5'd1;   // o
      7'h69: return 5'd2;   // i
      7'h4F: return 5'd3;   // O
      7'h6A: return 5'd4;   // j
      7'h70: return 5'd5;   // p
      7'h75: return 5'd6;   // u
      7'h50: return 5'd7;   // P
      7'h68: return 5'd8;   // h
      7'h79: return 5'd12;  // y
      7'h6E: return 5'd13;  // n
      7'h62: return 5'd17;  // b
      7'h6D: return 5'd18;  // m
      7'h6C: return 5'd20;  // l
      default: return NONE_JAMO;
    endcase
  endfunction

  // lead as tail, 0 when it cannot close a syllable
  function automatic logic [4:0] lead_as_tail(logic [4:0] l);
    case (l)
      5'd0:  return 5'd1;
      5'd1:  return 5'd2;
      5'd2:  return 5'd4;
      5'd3:  return 5'd7;
      5'd5:  return 5'd8;
      5'd6:  return 5'd16;
      5'd7:  return 5'd17;
      5'd9:  return 5'd19;
      5'd10: return 5'd20;
      5'd11: return 5'd21;
      5'd12: return 5'd22;
      5'd14: return 5'd23;
      5'd15: return 5'd24;
      5'd16: return 5'd25;
      5'd17: return 5'd26;
      5'd18: return 5'd27;
      default: return 5'd0;
    endcase
  endfunction

  // simple tail back to lead, none otherwise
  function automatic logic [4:0] lead_of_tail(logic [4:0] t);
    case (t)
      5'd1:  return 5'd0;
      5'd2:  return 5'd1;
      5'd4:  return 5'd2;
      5'd7:  return 5'd3;
      5'd8:  return 5'd5;
      5'd16: return 5'd6;
      5'd17: return 5'd7;
      5'd19: return 5'd9;
      5'd20: return 5'd10;
      5'd21: return 5'd11;
      5'd22: return 5'd12;
      5'd23: return 5'd14;
      5'd24: return 5'd15;
      5'd25: return 5'd16;
      5'd26: return 5'd17;
      5'd27: return 5'd18;
      default: return NONE_JAMO;
    endcase
  endfunction

  // first part of a compound tail, 0 when not compound
  function automatic logic [4:0] split_first(logic [4:0] t);
    case (t)
      5'd3:  return 5'd1;
      5'd5:  return 5'd4;
      5'd6:  return 5'd4;
      5'd9:  return 5'd8;
      5'd10: return 5'd8;
      5'd11: return 5'd8;
      5'd12: return 5'd8;
      5'd13: return 5'd8;
      5'd14: return 5'd8;
      5'd15: return 5'd8;
      5'd18: return 5'd17;
      default: return 5'd0;
    endcase
  endfunction

  // second part of a compound tail as a lead, none when not compound
  function automatic logic [4:0] split_lead(logic [4:0] t);
    case (t)
      5'd3:  return 5'd9;
      5'd5:  return 5'd12;
      5'd6:  return 5'd18;
      5'd9:  return 5'd0;
      5'd10: return 5'd6;
      5'd11: return 5'd7;
      5'd12: return 5'd9;
      5'd13: return 5'd16;
      5'd14: return 5'd17;
      5'd15: return 5'd18;
      5'd18: return 5'd9;
      default: return NONE_JAMO;
    endcase
  endfunction

  // tail plus lead into compound tail, 0 when no pair
  function automatic logic [4:0] join_tail(logic [4:0] t, logic [4:0] l);
    case ({t, l})
      {5'd1,  5'd9}:  return 5'd3;
      {5'd4,  5'd12}: return 5'd5;
      {5'd4,  5'd18}: return 5'd6;
      {5'd8,  5'd0}:  return 5'd9;
      {5'd8,  5'd6}:  return 5'd10;
      {5'd8,  5'd7}:  return 5'd11;
      {5'd8,  5'd9}:  return 5'd12;
      {5'd8,  5'd16}: return 5'd13;
      {5'd8,  5'd17}: return 5'd14;
      {5'd8,  5'd18}: return 5'd15;
      {5'd17, 5'd9}:  return 5'd18;
      default: return 5'd0;
    endcase
  endfunction

  // two vowels into compound vowel, none when no pair
  function automatic logic [4:0] join_vowel(logic [4:0] a, logic [4:0] b);
    case ({a, b})
      {5'd8,  5'd0}:  return 5'd9;
      {5'd8,  5'd1}:  return 5'd10;
      {5'd8,  5'd20}: return 5'd11;
      {5'd13, 5'd4}:  return 5'd14;
      {5'd13, 5'd5}:  return 5'd15;
      {5'd13, 5'd20}: return 5'd16;
      {5'd18, 5'd20}: return 5'd19;
      default: return NONE_JAMO;
    endcase
  endfunction

  // compound vowel back to its first vowel
  function automatic logic [4:0] vowel_base(logic [4:0] v);
    case (v)
      5'd9, 5'd10, 5'd11:  return 5'd8;
      5'd14, 5'd15, 5'd16: return 5'd13;
      5'd19:               return 5'd18;
      default:             return NONE_JAMO;
    endcase
  endfunction

  // compatibility code point of a lead
  function automatic logic [15:0] lead_compat(logic [4:0] l);
    logic [4:0] ofs;
    case (l)
      5'd0:  ofs = 5'd0;
      5'd1:  ofs = 5'd1;
      5'd2:  ofs = 5'd3;
      5'd3:  ofs = 5'd6;
      5'd4:  ofs = 5'd7;
      5'd5:  ofs = 5'd8;
      5'd6:  ofs = 5'd16;
      5'd7:  ofs = 5'd17;
      5'd8:  ofs = 5'd18;
      5'd9:  ofs = 5'd20;
      5'd10: ofs = 5'd21;
      5'd11: ofs = 5'd22;
      5'd12: ofs = 5'd23;
      5'd13: ofs = 5'd24;
      5'd14: ofs = 5'd25;
      5'd15: ofs = 5'd26;
      5'd16: ofs = 5'd27;
      5'd17: ofs = 5'd28;
      5'd18: ofs = 5'd29;
      default: ofs = 5'd0;
    endcase
    return LEAD_COMPAT_BASE + 16'(ofs);
  endfunction

  // precomposed syllable code point
  function automatic logic [15:0] syllable(logic [4:0] l, logic [4:0] v, logic [4:0] t);
    logic [9:0] lv;
    logic [4:0] tm;
    lv = 10'(l) * 10'(N_VOWELS) + 10'(v);
    tm = (t >= N_TAILS) ? t - N_TAILS : t;
    return SYL_BASE + 16'(lv) * 16'(N_TAILS) + 16'(tm);
  endfunction

  // preview code point of a composer state
  function automatic logic [15:0] preview(logic comp, logic ie, logic [4:0] l,
                                          logic [4:0] v, logic [4:0] t);
    logic lv_ok;
    logic vv_ok;
    lv_ok = (l < N_LEADS);
    vv_ok = (v < N_VOWELS);
    if (!comp) return 16'd0;
    if (ie && vv_ok && (t == 5'd0)) return VOWEL_COMPAT_BASE + 16'(v);
    if (lv_ok && vv_ok) return syllable(l, v, t);
    if (lv_ok) return lead_compat(l);
    if (vv_ok) return VOWEL_COMPAT_BASE + 16'(v);
    return 16'd0;
  endfunction

endpackage

// ----- sv/hts_ctrl.sv -----
`timescale 1ns / 1ps

module hts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hts_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   stall;

  // exec waits while the previous result is still held
  assign stall       = out_valid_q && !out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_EXEC) && !stall);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load   = in_valid_i && in_ready_o;
  assign cmd_o.decode = (state_q == ST_DECODE);
  assign cmd_o.exec   = (state_q == ST_EXEC) && !stall;

  // next state and result valid
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (!stall) state_d = cmd_o.load ? ST_DECODE : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/hts_dp.sv -----
`timescale 1ns / 1ps

module hts_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hts_pkg::cmd_t cmd_i,
  input  logic [1:0]    req_type_i,
  input  logic [20:0]   key_code_i,
  output logic          consumed_o,
  output logic          preedit_valid_o,
  output logic [15:0]   preedit_code_o,
  output logic          has_commit_o,
  output logic [15:0]   commit_code_o
);

  // captured transaction
  logic [1:0]  type_q;
  logic [20:0] key_q;

  // decode stage
  hts_pkg::req_e dtype_q;
  logic          dbig_q;
  logic [4:0]    dlead_q;
  logic [4:0]    dvowel_q;
  logic [15:0]   cur_pre_q;
  logic [15:0]   split_syl_q;

  // composer state
  logic       comp_q, comp_d;
  logic       ie_q, ie_d;
  logic [4:0] lead_q, lead_d;
  logic [4:0] vowel_q, vowel_d;
  logic [4:0] tail_q, tail_d;

  // exec results
  logic        consumed;
  logic [15:0] commit;
  logic [15:0] pre;
  logic [4:0]  tl;
  logic [4:0]  jn;
  logic [4:0]  sl;
  logic [4:0]  lt;

  // result registers
  logic        consumed_q;
  logic [15:0] pre_q;
  logic [15:0] commit_q;

  // input capture, jamo lookup and current preview
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q <= req_type_i;
      key_q  <= key_code_i;
    end
    if (cmd_i.decode) begin
      dtype_q     <= hts_pkg::req_e'(type_q);
      dbig_q      <= (key_q > hts_pkg::ASCII_MAX);
      dlead_q     <= hts_pkg::key_lead(key_q[6:0]);
      dvowel_q    <= hts_pkg::key_vowel(key_q[6:0]);
      cur_pre_q   <= hts_pkg::preview(comp_q, ie_q, lead_q, vowel_q, tail_q);
      split_syl_q <= hts_pkg::syllable(lead_q, vowel_q, hts_pkg::split_first(tail_q));
    end
  end

  // next composer state for one event
  always_comb begin
    comp_d   = comp_q;
    ie_d     = ie_q;
    lead_d   = lead_q;
    vowel_d  = vowel_q;
    tail_d   = tail_q;
    consumed = 1'b0;
    commit   = 16'd0;
    tl       = hts_pkg::lead_as_tail(dlead_q);
    jn       = hts_pkg::join_tail(tail_q, dlead_q);
    sl       = hts_pkg::split_lead(tail_q);
    lt       = hts_pkg::lead_of_tail(tail_q);
    case (dtype_q)
      hts_pkg::REQ_CHAR: begin
        if (!dbig_q) begin
          if ((dlead_q == hts_pkg::NONE_JAMO) && (dvowel_q == hts_pkg::NONE_JAMO)) begin
            // not a jamo key: flush and clear
            commit  = cur_pre_q;
            comp_d  = 1'b0;
            ie_d    = 1'b0;
            lead_d  = hts_pkg::NONE_JAMO;
            vowel_d = hts_pkg::NONE_JAMO;
            tail_d  = 5'd0;
          end else if (dvowel_q != hts_pkg::NONE_JAMO) begin
            consumed = 1'b1;
            if (!comp_q) begin
              comp_d  = 1'b1;
              ie_d    = 1'b1;
              lead_d  = hts_pkg::IEUNG;
              vowel_d = dvowel_q;
              tail_d  = 5'd0;
            end else if (vowel_q >= hts_pkg::N_VOWELS) begin
              vowel_d = dvowel_q;
            end else if (tail_q != 5'd0) begin
              // tail moves or splits into the next syllable
              commit  = split_syl_q;
              comp_d  = 1'b1;
              ie_d    = 1'b0;
              if (sl != hts_pkg::NONE_JAMO) begin
                lead_d = sl;
              end else if (lt != hts_pkg::NONE_JAMO) begin
                lead_d = lt;
              end else begin
                lead_d = hts_pkg::IEUNG;
              end
              vowel_d = dvowel_q;
              tail_d  = 5'd0;
            end else if (hts_pkg::join_vowel(vowel_q, dvowel_q) != hts_pkg::NONE_JAMO) begin
              vowel_d = hts_pkg::join_vowel(vowel_q, dvowel_q);
            end else begin
              commit  = cur_pre_q;
              comp_d  = 1'b1;
              ie_d    = 1'b1;
              lead_d  = hts_pkg::IEUNG;
              vowel_d = dvowel_q;
              tail_d  = 5'd0;
            end
          end else begin
            consumed = 1'b1;
            if (comp_q && (vowel_q < hts_pkg::N_VOWELS) && !(ie_q && (tail_q == 5'd0))
                && (tl != 5'd0) && (tail_q == 5'd0)) begin
              tail_d = tl;
            end else if (comp_q && (vowel_q < hts_pkg::N_VOWELS)
                         && !(ie_q && (tail_q == 5'd0)) && (tl != 5'd0) && (jn != 5'd0)) begin
              tail_d = jn;
            end else begin
              // consonant opens a new syllable
              commit  = comp_q ? cur_pre_q : 16'd0;
              comp_d  = 1'b1;
              ie_d    = 1'b0;
              lead_d  = dlead_q;
              vowel_d = hts_pkg::NONE_JAMO;
              tail_d  = 5'd0;
            end
          end
        end
      end
      hts_pkg::REQ_BACKSPACE: begin
        if (comp_q) begin
          consumed = 1'b1;
          if (tail_q != 5'd0) begin
            tail_d = hts_pkg::split_first(tail_q);
          end else if ((vowel_q < hts_pkg::N_VOWELS)
                       && (hts_pkg::vowel_base(vowel_q) != hts_pkg::NONE_JAMO)) begin
            vowel_d = hts_pkg::vowel_base(vowel_q);
          end else if ((vowel_q < hts_pkg::N_VOWELS) && !ie_q) begin
            vowel_d = hts_pkg::NONE_JAMO;
          end else begin
            comp_d  = 1'b0;
            ie_d    = 1'b0;
            lead_d  = hts_pkg::NONE_JAMO;
            vowel_d = hts_pkg::NONE_JAMO;
            tail_d  = 5'd0;
          end
        end
      end
      hts_pkg::REQ_RESET, hts_pkg::REQ_COMMIT: begin
        commit  = (dtype_q == hts_pkg::REQ_COMMIT) ? cur_pre_q : 16'd0;
        comp_d  = 1'b0;
        ie_d    = 1'b0;
        lead_d  = hts_pkg::NONE_JAMO;
        vowel_d = hts_pkg::NONE_JAMO;
        tail_d  = 5'd0;
      end
      default: begin
        commit = 16'd0;
      end
    endcase
    pre = consumed ? hts_pkg::preview(comp_d, ie_d, lead_d, vowel_d, tail_d) : 16'd0;
  end

  // composer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_q  <= 1'b0;
      ie_q    <= 1'b0;
      lead_q  <= hts_pkg::NONE_JAMO;
      vowel_q <= hts_pkg::NONE_JAMO;
      tail_q  <= 5'd0;
    end else if (cmd_i.exec) begin
      comp_q  <= comp_d;
      ie_q    <= ie_d;
      lead_q  <= lead_d;
      vowel_q <= vowel_d;
      tail_q  <= tail_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      consumed_q <= consumed;
      pre_q      <= pre;
      commit_q   <= commit;
    end
  end

  assign consumed_o      = consumed_q;
  assign preedit_valid_o = (pre_q != 16'd0);
  assign preedit_code_o  = pre_q;
  assign has_commit_o    = (commit_q != 16'd0);
  assign commit_code_o   = commit_q;

endmodule

// ----- sv/hangul_two_set_composer.sv -----
`timescale 1ns / 1ps
// sequence: an accepted transaction passes the lookup step, then the compose step,
//   which registers the result; the next input is taken during the compose step of the controller,
//   and a held result stalls the compose step and with it the input
// reset: asynchronous, active low; clears the controller and the syllable state
//   to nothing composed

module hangul_two_set_composer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [20:0] key_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        consumed_o,
  output logic        preedit_valid_o,
  output logic [15:0] preedit_code_o,
  output logic        has_commit_o,
  output logic [15:0] commit_code_o
);

  hts_pkg::cmd_t cmd;

  // sequencing and handshakes
  hts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // jamo lookup and syllable composition
  hts_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .req_type_i      (req_type_i),
    .key_code_i      (key_code_i),
    .consumed_o      (consumed_o),
    .preedit_valid_o (preedit_valid_o),
    .preedit_code_o  (preedit_code_o),
    .has_commit_o    (has_commit_o),
    .commit_code_o   (commit_code_o)
  );

  // an accepted transaction blocks the input during lookup
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready during lookup");

  // a key that is not used leaves no preview
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !consumed_o) |-> !preedit_valid_o)
    else $error("preview on unused key");

  // flags agree with code points
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((has_commit_o == (commit_code_o != 16'd0))
                     && (preedit_valid_o == (preedit_code_o != 16'd0))))
    else $error("flag and code point disagree");

endmodule
